[sv/aac_pkg.sv]
// shared types and constants for the adc averaging / cubic calibration block
// no dependencies; imported by every module of the block

package aac_pkg;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_COEF_CUBIC   = 3'd1;
    localparam logic [2:0] REG_COEF_SQUARE  = 3'd2;
    localparam logic [2:0] REG_COEF_LINEAR  = 3'd3;
    localparam logic [2:0] REG_COEF_OFFSET  = 3'd4;

    localparam int CNT_CFG_W = 16;
    localparam int COEF_W    = 32;

    // reset coefficients give the voltage channel
    localparam logic [CNT_CFG_W-1:0]     RST_SAMPLE_COUNT = 16'd16;
    localparam logic signed [COEF_W-1:0] RST_COEF_CUBIC   = 32'sd17922;
    localparam logic signed [COEF_W-1:0] RST_COEF_SQUARE  = -32'sd617925;
    localparam logic signed [COEF_W-1:0] RST_COEF_LINEAR  = 32'sd7279136;
    localparam logic signed [COEF_W-1:0] RST_COEF_OFFSET  = -32'sd25905800;

    // fixed-point layout
    localparam int FRAC_BITS   = 12;   // fraction bits of the mean
    localparam int STAGE_SHIFT = 20;   // floor shift after each horner product
    localparam int H_W         = 36;   // intermediate horner width
    localparam int Y_W         = 32;   // result width

    typedef struct packed {
        logic signed [COEF_W-1:0] cubic;
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] offset;
    } coef_set_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
        logic res_sat;
    } eng_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } eng_state_t;

endpackage

[sv/aac_engine.sv]
// batch engine: restoring divide for the mean, then horner evaluation of the cubic,
// all on one shared adder under a small sequencer
// depends on aac_pkg

module aac_engine import aac_pkg::*; #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ADC_BITS+COUNT_BITS-1:0] sum_in,
    input  logic [COUNT_BITS:0]            n_in,
    input  coef_set_t                      coef,
    input  logic                           res_ready,
    output eng_stat_t                      stat,
    output logic [Y_W-1:0]                 res_value
);

    localparam int SUM_W = ADC_BITS + COUNT_BITS;
    localparam int N_W   = COUNT_BITS + 1;
    localparam int DIV_W = SUM_W + FRAC_BITS;
    localparam int M_W   = ADC_BITS + FRAC_BITS;
    localparam int P_W   = H_W + M_W;
    localparam int ALU_W = P_W + 1;
    localparam int S_W   = P_W - STAGE_SHIFT;
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic [1:0] RND_SQUARE = 2'd0;
    localparam logic [1:0] RND_LINEAR = 2'd1;
    localparam logic [1:0] RND_OFFSET = 2'd2;

    eng_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]               round_reg, round_next;
    logic [DIV_W-1:0]         dq_reg, dq_next;
    logic [N_W-1:0]           rem_reg, rem_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [M_W-1:0]           mm_reg, mm_next;
    logic [H_W-1:0]           h_reg, h_next;
    logic [P_W-1:0]           acc_reg, acc_next;
    logic                     sat_reg, sat_next;
    logic [Y_W-1:0]           y_reg, y_next;

    logic [ALU_W-1:0]         alu_a, alu_b, alu_y;
    logic                     alu_sub;
    logic [COEF_W-1:0]        coef_sel;
    logic                     ok36, ok32;
    logic [H_W-1:0]           clip36;
    logic [Y_W-1:0]           clip32;
    logic                     qbit;

    always_comb begin
        case (round_reg)
            RND_SQUARE: coef_sel = coef.square;
            RND_LINEAR: coef_sel = coef.linear;
            default:    coef_sel = coef.offset;
        endcase
    end

    // the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_DIV: begin
                alu_a   = ALU_W'({rem_reg, dq_reg[DIV_W-1]});
                alu_b   = ALU_W'(n_reg);
                alu_sub = 1'b1;
            end
            ST_MUL: begin
                // msb-first shift and add: acc = 2*acc + bit*h
                alu_a = {acc_reg, 1'b0};
                alu_b = mm_reg[M_W-1] ? {{(ALU_W-H_W){h_reg[H_W-1]}}, h_reg} : '0;
            end
            ST_ADD: begin
                // floor shift of the product, plus the next coefficient
                alu_a = {{(ALU_W-S_W){acc_reg[P_W-1]}}, acc_reg[P_W-1:STAGE_SHIFT]};
                alu_b = {{(ALU_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    end

    assign qbit = ~alu_y[ALU_W-1];

    // saturation to signed 36 and signed 32 bits
    assign ok36 = (&alu_y[ALU_W-1:H_W-1]) | ~(|alu_y[ALU_W-1:H_W-1]);
    assign ok32 = (&alu_y[ALU_W-1:Y_W-1]) | ~(|alu_y[ALU_W-1:Y_W-1]);
    assign clip36 = ok36 ? alu_y[H_W-1:0] :
                    alu_y[ALU_W-1] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}};
    assign clip32 = ok32 ? alu_y[Y_W-1:0] :
                    alu_y[ALU_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        mm_next    = mm_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    dq_next    = {sum_in, {FRAC_BITS{1'b0}}};
                    rem_next   = '0;
                    n_next     = n_in;
                    cnt_next   = CNT_W'(DIV_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = qbit ? alu_y[N_W-1:0] : {rem_reg[N_W-2:0], dq_reg[DIV_W-1]};
                dq_next  = {dq_reg[DIV_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    // quotient fits in the mean width
                    mm_next    = dq_next[M_W-1:0];
                    h_next     = {{(H_W-COEF_W){coef.cubic[COEF_W-1]}}, coef.cubic};
                    acc_next   = '0;
                    sat_next   = 1'b0;
                    round_next = RND_SQUARE;
                    cnt_next   = CNT_W'(M_W - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next = alu_y[P_W-1:0];
                // rotate so the mean is intact for the next round
                mm_next  = {mm_reg[M_W-2:0], mm_reg[M_W-1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (round_reg == RND_OFFSET) begin
                    y_next     = clip32;
                    sat_next   = sat_reg | ~ok32;
                    state_next = ST_DONE;
                end else begin
                    h_next     = clip36;
                    sat_next   = sat_reg | ~ok36;
                    acc_next   = '0;
                    round_next = round_reg + 1'b1;
                    cnt_next   = CNT_W'(M_W - 1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            round_reg <= RND_SQUARE;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        n_reg   <= n_next;
        mm_reg  <= mm_next;
        h_reg   <= h_next;
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        y_reg   <= y_next;
    end

    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign stat.res_sat   = sat_reg;
    assign res_value      = y_reg;

endmodule

[sv/adc_average_cubic_calibration.sv]
// channel  | ports          | payload
// ---------+----------------+------------------------------------------------
// samples  | s_tvalid/ready | s_tdata: adc_sample (ADC_BITS, unsigned)
// results  | m_tvalid/ready | m_tdata: calibrated_value (32, signed Q16.16)
//          |                | m_tuser: saturated
// config   | apb            | sample_count, coef_cubic/square/linear/offset
//
// a sample that does not close the batch is only added to the sum and the count
// a closing sample starts the engine: ADC_BITS+COUNT_BITS+12 divide steps, then
// three horner rounds of shift-and-add steps and an add on the shared adder, then
// the hand-off of the result; s_tready is low meanwhile
// the result register frees the engine while m_tready is low, unless it already holds a result; reset is synchronous
// top level; depends on aac_pkg and aac_engine

module adc_average_cubic_calibration import aac_pkg::*; #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]    s_tdata,   // adc_sample
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [Y_W-1:0]                   m_tdata,   // calibrated_value
    output logic                             m_tuser,   // saturated
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ADDR_W-1:0]                paddr,
    input  logic [DATA_W-1:0]                pwdata,
    output logic [DATA_W-1:0]                prdata,
    output logic                             pready
);

    localparam int SUM_W = ADC_BITS + COUNT_BITS;
    localparam int N_W   = COUNT_BITS + 1;
    localparam int CMP_W = (N_W > CNT_CFG_W) ? N_W : CNT_CFG_W;

    logic [CNT_CFG_W-1:0]  count_reg, count_next;
    coef_set_t             coef_reg, coef_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] taken_reg, taken_next;
    logic                  mval_reg, mval_next;
    logic [Y_W-1:0]        mdata_reg, mdata_next;
    logic                  muser_reg, muser_next;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic                  s_xfer;
    logic [SUM_W-1:0]      sum_add;
    logic [N_W-1:0]        n_cur;
    logic [CNT_CFG_W-1:0]  target;
    logic                  close;
    logic                  eng_start;
    logic                  res_ready;
    eng_stat_t             eng_stat;
    logic [Y_W-1:0]        eng_value;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        count_next = count_reg;
        coef_next  = coef_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SAMPLE_COUNT: count_next       = pwdata[CNT_CFG_W-1:0];
                REG_COEF_CUBIC:   coef_next.cubic  = pwdata;
                REG_COEF_SQUARE:  coef_next.square = pwdata;
                REG_COEF_LINEAR:  coef_next.linear = pwdata;
                REG_COEF_OFFSET:  coef_next.offset = pwdata;
                default:          count_next       = count_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SAMPLE_COUNT: prdata = DATA_W'(count_reg);
            REG_COEF_CUBIC:   prdata = coef_reg.cubic;
            REG_COEF_SQUARE:  prdata = coef_reg.square;
            REG_COEF_LINEAR:  prdata = coef_reg.linear;
            REG_COEF_OFFSET:  prdata = coef_reg.offset;
            default:          prdata = '0;
        endcase
    end

    // batch accumulation
    assign s_tready = ~eng_stat.busy;
    assign s_xfer   = s_tvalid & s_tready;
    assign sum_add  = sum_reg + SUM_W'(s_tdata[ADC_BITS-1:0]);
    assign n_cur    = N_W'(taken_reg) + 1'b1;
    // a zero count behaves as a count of one
    assign target   = (count_reg == '0) ? CNT_CFG_W'(1) : count_reg;
    assign close    = CMP_W'(n_cur) >= CMP_W'(target);
    assign eng_start = s_xfer & close;

    always_comb begin
        sum_next   = sum_reg;
        taken_next = taken_reg;
        if (s_xfer) begin
            if (close) begin
                sum_next   = '0;
                taken_next = '0;
            end else begin
                sum_next   = sum_add;
                taken_next = n_cur[COUNT_BITS-1:0];
            end
        end
    end

    // result register
    assign res_ready = ~mval_reg | m_tready;

    always_comb begin
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        if (m_tready) begin
            mval_next = 1'b0;
        end
        if (eng_stat.res_valid && res_ready) begin
            mval_next  = 1'b1;
            mdata_next = eng_value;
            muser_next = eng_stat.res_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= RST_SAMPLE_COUNT;
            coef_reg.cubic  <= RST_COEF_CUBIC;
            coef_reg.square <= RST_COEF_SQUARE;
            coef_reg.linear <= RST_COEF_LINEAR;
            coef_reg.offset <= RST_COEF_OFFSET;
            sum_reg         <= '0;
            taken_reg       <= '0;
            mval_reg        <= 1'b0;
        end else begin
            count_reg <= count_next;
            coef_reg  <= coef_next;
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    aac_engine #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .sum_in    (sum_add),
        .n_in      (n_cur),
        .coef      (coef_reg),
        .res_ready (res_ready),
        .stat      (eng_stat),
        .res_value (eng_value)
    );

endmodule

[sv/aac_checker.sv]
// port-level checks for the averaging / calibration block, bound to the top level
// depends on aac_pkg

module aac_checker import aac_pkg::*; (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [Y_W-1:0] m_tdata,
    input logic           m_tuser
);

    // a stalled result transfer keeps its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a new result only comes out of a busy engine
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a batch in progress");

    // once a batch closes, s_tready is still low in the cycle after it falls
    a_busy_span: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |=> !s_tready)
        else $error("engine finished too early");

    // after reset the block takes samples and holds no result
    a_reset_state: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_tready && !m_tvalid)
        else $error("bad state after reset");

endmodule

bind adc_average_cubic_calibration aac_checker u_aac_checker (.*);
